[rtl/core/q16m_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package q16m_pkg;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_DIV  = 3'd1,
        OP_F2X  = 3'd2,
        OP_ABS  = 3'd3,
        OP_SQRT = 3'd4,
        OP_CBRT = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_FLT  = 2'd2,
        ST_NCNV = 2'd3
    } status_t;

    localparam logic [0:0] REG_TOL = 1'b0;
    localparam logic [0:0] REG_MAXIT = 1'b1;
endpackage
`default_nettype wire

[rtl/core/q16m_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shift-and-add signed multiplier, one multiplier bit per cycle.
module q16m_mul
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [63:0]      prod
);
    import q16m_pkg::*;
    logic [63:0] acc_reg, acc_next, mc_reg, mc_next;
    logic [31:0] mp_reg, mp_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next, done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            mc_next  = {{32{a[31]}}, a};
            mp_next  = b;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // The top multiplier bit carries negative weight.
            if (mp_reg[0])
                acc_next = (cnt_reg == 6'd31) ? acc_reg - mc_reg : acc_reg + mc_reg;
            mc_next  = {mc_reg[62:0], 1'b0};
            mp_next  = {1'b0, mp_reg[31:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

[rtl/core/q16m_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider for a signed 64-bit dividend and a 32-bit divisor,
// one quotient bit per cycle on magnitudes, truncating toward zero.
module q16m_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic             fault,
    output logic [31:0]      quo
);
    import q16m_pkg::*;
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next, run_reg, run_next, done_reg, done_next;
    logic        dz_reg, dz_next;
    logic [33:0] trial;
    logic [63:0] sq;
    logic        ovf;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        run_next  = run_reg;
        dz_next   = dz_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[63]} - {2'b00, d_reg};
        if (start)
        begin
            q_next   = num[63] ? (~num + 64'd1) : num;
            d_next   = den[31] ? (~den + 32'd1) : den;
            r_next   = '0;
            neg_next = num[63] ^ den[31];
            dz_next  = (den == '0);
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
    end

    // Magnitude limit is 2^31 for a negative quotient, 2^31-1 otherwise.
    assign sq = neg_reg ? (~q_reg + 64'd1) : q_reg;
    always_comb
    begin
        if (neg_reg)
            ovf = (q_reg > 64'h0000_0000_8000_0000);
        else
            ovf = (q_reg > 64'h0000_0000_7fff_ffff);
    end
    assign done  = done_reg;
    assign fault = dz_reg | ovf;
    assign quo   = sq[31:0];
endmodule
`default_nettype wire

[rtl/core/q16_fixed_point_math_unit_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Signed fixed-point math unit with FRAC_BITS fractional bits. A word on the
// input stream selects multiply, divide, float to fixed, absolute value,
// square root or cube root, and one result word comes back for each input
// word. One word is worked on at a time: tready is high only while the unit
// is idle. Arithmetic runs through a bit-serial multiplier and a bit-serial
// divider, one bit per cycle; the division by three in a cube root step is
// also done one bit per cycle. Float to fixed, absolute value and the unused
// request codes go straight to the output state; multiply and divide wait
// for the multiplier or divider. A square root step is one division, a cube
// root step a squaring, a division and the division by three, and a root
// stops after the step that reaches the iteration cap. The result is held in
// an output register until taken, while the next word is already accepted;
// if that register is still full when a result is ready, the unit waits.
// Register 0 is the Newton tolerance and register 1 the iteration cap; the
// user is to write them on the plain write port only while idle, and the
// block itself does not enforce this.
module q16_fixed_point_math_unit_top
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: operand_a[31:0], operand_b[63:32], float_bits[95:64]
    input  wire logic [95:0] s_tdata,
    // tuser: req_type[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: result[31:0]
    output logic [31:0]      m_tdata,
    // tuser: status[1:0]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import q16m_pkg::*;

    localparam int EXP_BASE = 150 - FRAC_BITS;
    localparam int EXP_LOW  = EXP_BASE - 24;
    localparam int EXP_HIGH = EXP_BASE + 7;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_TSQ   = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_THIRD = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] tol_reg;
    logic [7:0]  maxit_reg;
    logic [2:0]  op_reg, op_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, t_reg, t_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;
    logic [7:0]  it_reg, it_next;
    logic [33:0] dt_reg, dt_next;
    logic        ov_reg, ov_next;
    logic [31:0] ob_res_reg;
    logic [1:0]  ob_st_reg;
    logic        ob_valid_reg;
    logic        mul_start, mul_done, div_start, div_done;
    logic [31:0] mul_a, mul_b, quo;
    logic [63:0] prod, prod_sh, div_num;
    logic [31:0] div_den;
    logic        div_fault;
    logic [32:0] diff;
    logic [33:0] diff_mag;
    logic [33:0] d3_reg, d3_next;
    logic [1:0]  d3_rem_reg, d3_rem_next;
    logic [5:0]  d3_cnt_reg, d3_cnt_next;
    logic [2:0]  d3_part;
    logic [33:0] dt_mag;
    logic [31:0] f_in, a_in;
    logic [7:0]  f_exp;
    logic [31:0] f_mag;
    logic        in_acc;

    assign in_acc = s_tvalid & s_tready;
    assign f_in   = s_tdata[95:64];
    assign a_in   = s_tdata[31:0];
    assign f_exp  = f_in[30:23];

    q16m_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    q16m_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .fault (div_fault),
        .quo   (quo)
    );

    assign prod_sh      = $signed(prod) >>> FRAC_BITS;
    assign div_num      = {{(32 - FRAC_BITS){a_reg[31]}}, a_reg, {FRAC_BITS{1'b0}}};
    // Exact difference q - t, 33 bits signed.
    assign diff         = {quo[31], quo} - {t_reg[31], t_reg};
    assign diff_mag     = diff[32] ? (~{diff[32], diff} + 34'd1) : {diff[32], diff};

    always_comb
    begin
        f_mag = '0;
        if (f_exp > 8'(EXP_BASE))
            f_mag = {8'd0, 1'b1, f_in[22:0]} << (f_exp - 8'(EXP_BASE));
        else
            f_mag = {8'd0, 1'b1, f_in[22:0]} >> (8'(EXP_BASE) - f_exp);
    end

    assign dt_mag = dt_reg[33] ? (~dt_reg + 34'd1) : dt_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        t_next        = t_reg;
        res_next      = res_reg;
        st_next       = st_reg;
        it_next       = it_reg;
        dt_next       = dt_reg;
        ov_next       = ov_reg;
        d3_next       = d3_reg;
        d3_rem_next   = d3_rem_reg;
        d3_cnt_next   = d3_cnt_reg;
        d3_part       = {d3_rem_reg, d3_reg[33]};
        mul_start     = 1'b0;
        div_start     = 1'b0;
        mul_a         = t_reg;
        mul_b         = t_reg;
        div_den       = t_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = s_tuser;
                    a_next   = a_in;
                    b_next   = s_tdata[63:32];
                    t_next   = 32'(2) << FRAC_BITS;
                    it_next  = '0;
                    res_next = '0;
                    st_next  = ST_OK;
                    state_next = S_OUT;
                    if (s_tuser == OP_MUL)
                    begin
                        mul_a = a_in;
                        mul_b = s_tdata[63:32];
                        mul_start = 1'b1;
                        state_next = S_MUL;
                    end
                    else if (s_tuser == OP_DIV)
                    begin
                        state_next = S_DIV;
                        ov_next = 1'b1;
                    end
                    else if (s_tuser == OP_F2X)
                    begin
                        if (f_in[30:0] == '0)
                            res_next = '0;
                        else if (f_exp == 8'hff || f_exp < 8'(EXP_LOW)
                                 || f_exp > 8'(EXP_HIGH))
                            st_next = ST_FLT;
                        else
                            res_next = f_in[31] ? (~f_mag + 32'd1) : f_mag;
                    end
                    else if (s_tuser == OP_ABS)
                        res_next = a_in[31] ? (~a_in + 32'd1) : a_in;
                    else if (s_tuser == OP_SQRT)
                    begin
                        state_next = S_DIV;
                        ov_next = 1'b0;
                    end
                    else if (s_tuser == OP_CBRT)
                    begin
                        // The first square is of the starting estimate 2.0.
                        mul_a = 32'(2) << FRAC_BITS;
                        mul_b = 32'(2) << FRAC_BITS;
                        mul_start = 1'b1;
                        state_next = S_TSQ;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    res_next = prod_sh[31:0];
                    state_next = S_OUT;
                end
            end
            S_TSQ:
            begin
                if (mul_done)
                begin
                    b_next = prod_sh[31:0];
                    state_next = S_DIV;
                    ov_next = 1'b0;
                end
            end
            S_DIV:
            begin
                // A clear ov_reg marks the first cycle here: launch the divider.
                div_den = (op_reg == OP_DIV) ? b_reg
                        : (op_reg == OP_CBRT) ? b_reg : t_reg;
                if (div_done)
                begin
                    if (div_fault)
                    begin
                        st_next = ST_DIVZ;
                        state_next = S_OUT;
                    end
                    else if (op_reg == OP_DIV)
                    begin
                        res_next = quo;
                        state_next = S_OUT;
                    end
                    else if (op_reg == OP_SQRT)
                    begin
                        // Halve toward zero.
                        dt_next = {diff[32], diff} + {33'd0, diff[32] & diff[0]};
                        dt_next = {dt_next[33], dt_next[33:1]};
                        state_next = S_STEP;
                    end
                    else
                    begin
                        dt_next = {diff[32], diff};
                        d3_next = diff_mag;
                        d3_rem_next = '0;
                        d3_cnt_next = '0;
                        it_next = it_reg;
                        state_next = S_THIRD;
                    end
                end
            end
            S_THIRD:
            begin
                // Long division of the difference magnitude by three, one
                // quotient bit per cycle; the sign is put back at the end.
                if (d3_part >= 3'd3)
                begin
                    d3_rem_next = 2'(d3_part - 3'd3);
                    d3_next = {d3_reg[32:0], 1'b1};
                end
                else
                begin
                    d3_rem_next = d3_part[1:0];
                    d3_next = {d3_reg[32:0], 1'b0};
                end
                d3_cnt_next = d3_cnt_reg + 6'd1;
                if (d3_cnt_reg == 6'd33)
                begin
                    dt_next = dt_reg[33] ? (~d3_next + 34'd1) : d3_next;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                t_next  = t_reg + dt_reg[31:0];
                it_next = it_reg + 8'd1;
                if (dt_mag <= {18'd0, tol_reg})
                begin
                    res_next = t_next;
                    state_next = S_OUT;
                end
                else if ((it_reg + 8'd1) >= maxit_reg)
                begin
                    st_next = ST_NCNV;
                    state_next = S_OUT;
                end
                else if (op_reg == OP_CBRT)
                begin
                    mul_a = t_next;
                    mul_b = t_next;
                    mul_start = 1'b1;
                    state_next = S_TSQ;
                end
                else
                begin
                    state_next = S_DIV;
                    ov_next = 1'b0;
                end
            end
            S_OUT:
            begin
                if (!ob_valid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_DIV && !ov_reg)
        begin
            div_start = 1'b1;
            ov_next = 1'b1;
        end
        if (state_reg == S_IDLE && in_acc && s_tuser == OP_DIV)
            ov_next = 1'b0;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tol_reg      <= 16'd6;
            maxit_reg    <= 8'd64;
            ob_valid_reg <= 1'b0;
            ov_reg       <= 1'b1;
            it_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            it_reg    <= it_next;
            if (cfg_we && cfg_index == REG_TOL)
                tol_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_MAXIT)
                maxit_reg <= cfg_wdata[7:0];
            if (state_reg == S_OUT && (!ob_valid_reg || m_tready))
                ob_valid_reg <= 1'b1;
            else if (m_tready)
                ob_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        t_reg      <= t_next;
        res_reg    <= res_next;
        st_reg     <= st_next;
        dt_reg     <= dt_next;
        d3_reg     <= d3_next;
        d3_rem_reg <= d3_rem_next;
        d3_cnt_reg <= d3_cnt_next;
        if (state_reg == S_OUT && (!ob_valid_reg || m_tready))
        begin
            ob_res_reg <= (st_reg == ST_OK) ? res_reg : '0;
            ob_st_reg  <= st_reg;
        end
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = ob_res_reg;
    assign m_tuser  = ob_st_reg;
endmodule
`default_nettype wire

[rtl/core/q16m_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module q16m_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import q16m_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == 32'd0)
        else $error("nonzero result with error status");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second word while busy");
endmodule

bind q16_fixed_point_math_unit_top q16m_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[tb/sv/tb_q16_fixed_point_math_unit_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the Q16.16 math unit. Words are queued by the
// stimulus process, pushed onto the input stream by a clocked driver with
// random gaps, and every word taken by the unit is run through a local
// predictor. The monitor compares each result word, field by field, with
// the oldest prediction.
module tb_q16_fixed_point_math_unit_top;
    import q16m_pkg::*;

    // One request word as the bench sees it.
    typedef struct {
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] fbits;
    } math_req_t;

    // One predicted result word.
    typedef struct {
        logic [31:0] result;
        logic [1:0]  status;
    } math_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    // Local copies of the two registers, updated with every write.
    logic [15:0] tol_copy;
    logic [7:0]  maxit_copy;

    math_req_t pending_reqs[$];
    math_res_t expected_results[$];
    int        error_count;
    bit        word_taken;
    int        send_gap;
    int        recv_gap;
    int        hold_cycles;
    bit        hold_request;

    q16_fixed_point_math_unit_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sign-extend the low 32 bits, which is also the 32-bit wrap.
    function automatic longint wrap32(longint v);
        return longint'($signed(v[31:0]));
    endfunction

    // Full product, floor shift by the fraction width, then wrap.
    function automatic longint fix_mul(longint a, longint b);
        longint p;
        p = a * b;
        return wrap32(p >>> 16);
    endfunction

    // Quotient truncated toward zero; returns 0 on a zero divisor or overflow.
    function automatic bit fix_div(longint a, longint b, output longint q);
        longint n;
        q = 0;
        if (b == 0)
            return 1'b0;
        n = a * 65536;
        q = n / b;
        if (q < -64'sd2147483648 || q > 64'sd2147483647)
            return 1'b0;
        return 1'b1;
    endfunction

    // Newton iteration from 2.0 for square or cube root.
    function automatic math_res_t newton_root(longint x, bit cube);
        math_res_t r;
        longint t;
        longint den;
        longint q;
        longint dt;
        longint mag;
        int n;
        t = 64'sd131072;
        n = 0;
        r.result = '0;
        forever
        begin
            den = cube ? fix_mul(t, t) : t;
            if (!fix_div(x, den, q))
            begin
                r.status = ST_DIVZ;
                return r;
            end
            dt = (q - t) / (cube ? 3 : 2);
            t = wrap32(t + dt);
            n++;
            mag = (dt < 0) ? -dt : dt;
            if (mag <= longint'(tol_copy))
            begin
                r.result = t[31:0];
                r.status = ST_OK;
                return r;
            end
            if (n >= int'(maxit_copy))
            begin
                r.status = ST_NCNV;
                return r;
            end
        end
    endfunction

    // IEEE single to Q16.16; status is ST_FLT outside biased exponents 110..141.
    function automatic math_res_t float_to_fix(logic [31:0] f);
        math_res_t r;
        int unsigned e;
        longint m;
        longint mag;
        r.result = '0;
        r.status = ST_OK;
        if (f[30:0] == 0)
            return r;
        e = f[30:23];
        if (e == 255 || e < 110 || e > 141)
        begin
            r.status = ST_FLT;
            return r;
        end
        m = longint'({1'b1, f[22:0]});
        if (e > 134)
            mag = m << (e - 134);
        else
            mag = m >> (134 - e);
        r.result = f[31] ? 32'(-mag) : 32'(mag);
        return r;
    endfunction

    function automatic math_res_t predict_math(math_req_t q);
        math_res_t r;
        longint a;
        longint b;
        longint v;
        a = longint'($signed(q.a));
        b = longint'($signed(q.b));
        r.result = '0;
        r.status = ST_OK;
        case (q.op)
            OP_MUL:  r.result = fix_mul(a, b);
            OP_DIV:
            begin
                if (fix_div(a, b, v))
                    r.result = v[31:0];
                else
                    r.status = ST_DIVZ;
            end
            OP_F2X:  r = float_to_fix(q.fbits);
            OP_ABS:  r.result = wrap32((a < 0) ? -a : a);
            OP_SQRT: r = newton_root(a, 1'b0);
            OP_CBRT: r = newton_root(a, 1'b1);
            default: r.result = '0;
        endcase
        if (r.status != ST_OK)
            r.result = '0;
        return r;
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff);
            2:       return 32'($urandom_range(0, 8)) << 16;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7fffffff;
                    1:       return 32'h80000000;
                    2:       return 32'hffffffff;
                    default: return 32'h00000000;
                endcase
            end
        endcase
    endfunction

    function automatic math_req_t random_req();
        math_req_t q;
        int unsigned r;
        q.a = pick_operand();
        q.b = pick_operand();
        q.fbits = $urandom;
        r = $urandom_range(0, 19);
        if (r < 3)
            q.op = OP_MUL;
        else if (r < 6)
            q.op = OP_DIV;
        else if (r < 9)
            q.op = OP_F2X;
        else if (r < 11)
            q.op = OP_ABS;
        else if (r < 15)
            q.op = OP_SQRT;
        else if (r < 18)
            q.op = OP_CBRT;
        else
            q.op = 3'($urandom_range(6, 7));
        // Conversions mostly land near the legal exponent window.
        if (q.op == OP_F2X && $urandom_range(0, 9) < 7)
            q.fbits = {1'($urandom), 8'($urandom_range(105, 146)), 23'($urandom)};
        // Roots mostly get a non-negative radicand of moderate size, so that they converge.
        if ((q.op == OP_SQRT || q.op == OP_CBRT) && $urandom_range(0, 9) < 7)
            q.a = $urandom_range(0, 32'h00ffffff);
        return q;
    endfunction

    function automatic math_req_t make_req(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                                           logic [31:0] f);
        math_req_t q;
        q.op = op;
        q.a = a;
        q.b = b;
        q.fbits = f;
        return q;
    endfunction

    // Driver: the word on the bus holds until the unit takes it, then the
    // next one is loaded after its random gap.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || word_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                math_req_t q;
                q = pending_reqs.pop_front();
                s_tdata <= {q.fbits, q.b, q.a};
                s_tuser <= q.op;
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random gaps on tready, plus one long hold-off on request
    // so that the unit fills up and stalls its input.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_request && hold_cycles == 0)
        begin
            hold_request <= 1'b0;
            hold_cycles <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= (hold_cycles == 1);
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (m_tready && m_tvalid)
                recv_gap <= pick_gap();
        end
    end

    // Input acceptance: predict from the word as it is taken.
    always @(posedge clk)
    begin
        word_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(predict_math(make_req(s_tuser, s_tdata[31:0],
                                                             s_tdata[63:32], s_tdata[95:64])));
    end

    // Monitor: every result word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word result=%h status=%0d",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                math_res_t e;
                e = expected_results.pop_front();
                if (m_tdata !== e.result)
                begin
                    $display("%0t: result mismatch expected=%h actual=%h",
                             $time, e.result, m_tdata);
                    error_count++;
                end
                if (m_tuser !== e.status)
                begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, e.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Wait until every queued word has been sent and every result returned.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Register write while the unit is idle; the local copy follows it.
    task automatic write_reg(logic idx, logic [15:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        if (idx == REG_TOL)
            tol_copy = value;
        else
            maxit_copy = value[7:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_random(int count);
        repeat (count) pending_reqs.push_back(random_req());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        tol_copy = 16'd6;
        maxit_copy = 8'd64;
        error_count = 0;
        word_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        hold_request = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at the reset settings.
        pending_reqs.push_back(make_req(OP_MUL, 32'h7fffffff, 32'h7fffffff, 0));
        pending_reqs.push_back(make_req(OP_MUL, 32'h80000000, 32'h80000000, 0));
        // Tiny negative product floors to minus one unit.
        pending_reqs.push_back(make_req(OP_MUL, 32'hffffffff, 32'h00000001, 0));
        pending_reqs.push_back(make_req(OP_DIV, 32'h00030000, 32'h00000000, 0));
        pending_reqs.push_back(make_req(OP_DIV, 32'h7fffffff, 32'h00000001, 0));
        pending_reqs.push_back(make_req(OP_DIV, 32'h80000000, 32'h00010000, 0));
        pending_reqs.push_back(make_req(OP_DIV, 32'hfffeffff, 32'h00030000, 0));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, 32'h00000000));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, 32'h80000000));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, {1'b0, 8'd110, 23'h7fffff}));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, {1'b1, 8'd141, 23'h7fffff}));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, {1'b0, 8'd109, 23'h000001}));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, {1'b1, 8'd142, 23'h000000}));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, 32'h7f800000));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, 32'h7fc00001));
        pending_reqs.push_back(make_req(OP_F2X, 0, 0, 32'h00000123));
        pending_reqs.push_back(make_req(OP_ABS, 32'h80000000, 0, 0));
        pending_reqs.push_back(make_req(OP_ABS, 32'hfffffffb, 0, 0));
        pending_reqs.push_back(make_req(OP_SQRT, 32'h00040000, 0, 0));
        pending_reqs.push_back(make_req(OP_SQRT, 32'h00000000, 0, 0));
        pending_reqs.push_back(make_req(OP_SQRT, 32'hfffc0000, 0, 0));
        pending_reqs.push_back(make_req(OP_CBRT, 32'h001b0000, 0, 0));
        pending_reqs.push_back(make_req(OP_CBRT, 32'hffe50000, 0, 0));
        pending_reqs.push_back(make_req(3'd6, 32'h12345678, 32'h9abcdef0, 32'hffffffff));
        pending_reqs.push_back(make_req(3'd7, 32'hffffffff, 32'hffffffff, 32'h3f800000));
        wait_drained();

        // Zero tolerance; the long receiver hold-off happens in this phase.
        write_reg(REG_TOL, 16'd0);
        hold_request = 1'b1;
        run_random(150);

        // Widest settings: largest tolerance and largest cap.
        write_reg(REG_TOL, 16'hffff);
        write_reg(REG_MAXIT, 16'd255);
        run_random(40);

        // A cap of one step.
        write_reg(REG_TOL, 16'd6);
        write_reg(REG_MAXIT, 16'd1);
        run_random(150);

        // Only the low byte of the cap counts, so this writes a cap of zero.
        write_reg(REG_TOL, 16'd100);
        write_reg(REG_MAXIT, 16'hff00);
        run_random(100);

        write_reg(REG_TOL, 16'd6);
        write_reg(REG_MAXIT, 16'd20);
        run_random(160);

        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
